[src/upd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and character constants for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DEL        = 8'h7F;

    // Input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // One command from front to back: 1..3 bytes, last flag on the final one
    typedef struct packed {
        logic [1:0]      count;
        logic            last;
        logic [2:0][7:0] data;
    } t_cmd;

endpackage

[src/url_percent_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// Path: each taken byte's command is queued, then loaded into the result register.
// Throughput: one byte in and one decoded byte out per cycle while the queue
// has room and results popped; two or three results of a byte go out in turn.
// Reset (synchronous, active low) clears escape state, query mode, queue
// and output register.
// ----------------------------------------------------------------------------
// URL percent decoder. The front tracks '%' escapes and turns every input
// item into a command of zero to three output bytes. Commands wait in a short
// queue; the back emits them one byte per cycle into a one-item result
// register while it is free or popped; input and output stall independently.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input queue side
    input  logic               push,
    output logic               full,
    input  upd_pkg::t_in_item  i_in_item,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output upd_pkg::t_out_item o_out_item,
    // query_mode register
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);

    logic          accept;
    logic          cmd_wr, cmd_rd, cmd_valid;
    upd_pkg::t_cmd cmd_in, cmd_head;

    // an item is taken whenever the command queue has room
    assign accept = push && !full;

    upd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd_valid (cmd_wr),
        .o_cmd       (cmd_in)
    );

    // full comes straight from the queue count, so it is registered
    upd_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wdata (cmd_in),
        .i_rd    (cmd_rd),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_rdata (cmd_head)
    );

    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_rd),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item)
    );

endmodule

[src/upd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front
// Takes raw bytes, tracks the escape state and builds output commands.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  upd_pkg::t_in_item i_item,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    output logic            o_cmd_valid,
    output upd_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        ESC_NONE  = 3'b001,
        ESC_PCT   = 3'b010,
        ESC_DIGIT = 3'b100
    } t_esc;

    t_esc       r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic [3:0] r_held_val, n_held_val;
    logic       r_query_mode;

    logic [7:0] b;
    logic       last;
    logic       b_hex;
    logic [3:0] b_val;
    logic [7:0] decoded, decoded_safe;
    logic       p_open, p_emit;
    logic [7:0] p_byte;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        // {valid, value}
        logic [4:0] r;
        r = 5'b0_0000;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    assign b    = i_item.in_byte;
    assign last = i_item.in_last;
    assign {b_hex, b_val} = hex_digit(b);

    assign decoded      = {r_held_val, b_val};
    assign decoded_safe = (decoded < 8'd32 || decoded == upd_pkg::CH_DEL)
                          ? upd_pkg::CH_UNDERSCORE : decoded;

    // Ordinary-byte handling
    always_comb begin
        p_open = 1'b0;
        p_emit = 1'b1;
        p_byte = b;
        if (b == upd_pkg::CH_PERCENT) begin
            p_open = !last;
            p_emit = last;
        end else if (r_query_mode && b == upd_pkg::CH_PLUS) begin
            p_byte = upd_pkg::CH_SPACE;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_held      = r_held;
        n_held_val  = r_held_val;
        o_cmd       = '0;
        o_cmd.last  = last;
        o_cmd_valid = 1'b0;
        case (r_phase)
            ESC_PCT: begin
                if (b_hex) begin
                    if (last) begin
                        o_cmd.count   = 2'd2;
                        o_cmd.data[0] = upd_pkg::CH_PERCENT;
                        o_cmd.data[1] = b;
                        n_phase       = ESC_NONE;
                    end else begin
                        n_held     = b;
                        n_held_val = b_val;
                        n_phase    = ESC_DIGIT;
                    end
                end else begin
                    o_cmd.data[0] = upd_pkg::CH_PERCENT;
                    o_cmd.data[1] = p_byte;
                    o_cmd.count   = p_emit ? 2'd2 : 2'd1;
                    n_phase       = p_open ? ESC_PCT : ESC_NONE;
                end
            end
            ESC_DIGIT: begin
                if (b_hex) begin
                    o_cmd.count   = 2'd1;
                    o_cmd.data[0] = decoded_safe;
                    n_phase       = ESC_NONE;
                end else begin
                    o_cmd.data[0] = upd_pkg::CH_PERCENT;
                    o_cmd.data[1] = r_held;
                    o_cmd.data[2] = p_byte;
                    o_cmd.count   = p_emit ? 2'd3 : 2'd2;
                    n_phase       = p_open ? ESC_PCT : ESC_NONE;
                end
            end
            default: begin
                o_cmd.data[0] = p_byte;
                o_cmd.count   = p_emit ? 2'd1 : 2'd0;
                n_phase       = p_open ? ESC_PCT : ESC_NONE;
            end
        endcase
        o_cmd_valid = i_accept && (o_cmd.count != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ESC_NONE;
            r_held       <= '0;
            r_held_val   <= '0;
            r_query_mode <= 1'b0;
        end else begin
            if (i_accept) begin
                r_phase    <= n_phase;
                r_held     <= n_held;
                r_held_val <= n_held_val;
            end
            if (i_cfg_we) begin
                r_query_mode <= i_cfg_wdata;
            end
        end
    end

endmodule

[src/upd_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_cmd_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module upd_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  upd_pkg::t_cmd i_wdata,
    input  logic          i_rd,
    output logic          o_full,
    output logic          o_valid,
    output upd_pkg::t_cmd o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    upd_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : AW'(r_wptr + 1'b1);
            end
            if (i_rd) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : AW'(r_rptr + 1'b1);
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= CW'(r_count + 1'b1);
                2'b01:   r_count <= CW'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/upd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back
// Walks commands into the result register, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  upd_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output logic              empty,
    input  logic              pop,
    output upd_pkg::t_out_item o_out_item
);

    logic [1:0]         r_idx;
    logic               r_out_valid;
    upd_pkg::t_out_item r_out;
    logic               can_load, emit, final_byte;

    assign can_load   = !r_out_valid || pop;
    assign emit       = i_cmd_valid && can_load;
    assign final_byte = (r_idx == 2'(i_cmd.count - 2'd1));
    assign o_cmd_pop  = emit && final_byte;
    assign empty      = !r_out_valid;
    assign o_out_item = r_out;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.out_byte <= i_cmd.data[r_idx];
            r_out.out_last <= i_cmd.last && final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_idx <= final_byte ? 2'd0 : 2'(r_idx + 2'd1);
            end
            if (can_load) begin
                r_out_valid <= emit;
            end
        end
    end

endmodule

[dv/url_percent_decoder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_checker
// Watches both queues of the decoder, predicts the decoded bytes of every
// accepted item and compares them in order with the items that are popped.
// ----------------------------------------------------------------------------
module url_percent_decoder_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  upd_pkg::t_in_item  i_in_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  upd_pkg::t_out_item i_out_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PERCENT,
        ESC_DIGIT
    } t_esc_phase;

    t_esc_phase          esc_phase;
    logic [7:0]          held_digit;
    logic                query_mode;
    upd_pkg::t_out_item  decoded_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        esc_phase    = ESC_NONE;
        held_digit   = '0;
        query_mode   = 1'b0;
    end

    // {valid, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
        return 5'b0;
    endfunction

    task automatic emit(input logic [7:0] b, input logic l);
        upd_pkg::t_out_item r;
        r.out_byte = b;
        r.out_last = l;
        decoded_q.push_back(r);
    endtask

    // byte seen with no escape open
    task automatic take_plain(input logic [7:0] b, input logic l);
        if (b == upd_pkg::CH_PERCENT) begin
            if (l) emit(upd_pkg::CH_PERCENT, 1'b1);
            esc_phase = l ? ESC_NONE : ESC_PERCENT;
        end else begin
            esc_phase = ESC_NONE;
            emit((query_mode && b == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : b, l);
        end
    endtask

    task automatic predict_decode(input logic [7:0] b, input logic l);
        logic [4:0] nib;
        logic [4:0] held_nib;
        logic [7:0] d;
        nib = hex_nibble(b);
        case (esc_phase)
            ESC_PERCENT: begin
                if (nib[4] && l) begin
                    emit(upd_pkg::CH_PERCENT, 1'b0);
                    emit(b, 1'b1);
                    esc_phase = ESC_NONE;
                end else if (nib[4]) begin
                    held_digit = b;
                    esc_phase  = ESC_DIGIT;
                end else begin
                    emit(upd_pkg::CH_PERCENT, 1'b0);
                    take_plain(b, l);
                end
            end
            ESC_DIGIT: begin
                if (nib[4]) begin
                    held_nib = hex_nibble(held_digit);
                    d = {held_nib[3:0], nib[3:0]};
                    if (d < upd_pkg::CH_SPACE || d == upd_pkg::CH_DEL)
                        d = upd_pkg::CH_UNDERSCORE;
                    emit(d, l);
                    esc_phase = ESC_NONE;
                end else begin
                    emit(upd_pkg::CH_PERCENT, 1'b0);
                    emit(held_digit, 1'b0);
                    take_plain(b, l);
                end
            end
            default: take_plain(b, l);
        endcase
    endtask

    task automatic note_failure(input string what, input upd_pkg::t_out_item exp_r,
                                input upd_pkg::t_out_item act_r);
        if (o_fail_count < 10)
            $display("[%0t] %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $realtime, what, exp_r.out_byte, exp_r.out_last,
                     act_r.out_byte, act_r.out_last);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        upd_pkg::t_out_item exp_r;
        if (!i_rst_n) begin
            decoded_q.delete();
            esc_phase  = ESC_NONE;
            held_digit = '0;
            query_mode = 1'b0;
        end else begin
            if (i_pop && !i_empty) begin
                if (decoded_q.size() == 0) begin
                    note_failure("item with nothing expected", '0, i_out_item);
                end else begin
                    exp_r = decoded_q.pop_front();
                    if (i_out_item.out_byte !== exp_r.out_byte ||
                        i_out_item.out_last !== exp_r.out_last)
                        note_failure("decoded item differs", exp_r, i_out_item);
                    o_checked++;
                end
            end
            if (i_push && !i_full)
                predict_decode(i_in_item.in_byte, i_in_item.in_last);
            // only written while idle, so ordering against items is moot
            if (i_cfg_we) query_mode = i_cfg_wdata;
        end
        o_pending = decoded_q.size();
    end

endmodule

[dv/tb_url_percent_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_url_percent_decoder_unit
// Drives encoded URL strings into the decoder in path and query mode and
// lets the checker compare every decoded item against its own prediction.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder_unit;

    localparam int CYCLE_LIMIT  = 200000;
    // margin for a byte to pass the command queue and the output register
    localparam int SETTLE_TICKS = 6;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    upd_pkg::t_in_item   in_item;
    logic                empty;
    logic                pop = 1'b0;
    upd_pkg::t_out_item  out_item;
    logic                cfg_we;
    logic                cfg_wdata;

    int fail_count;
    int pending;
    int checked;
    int in_gap_pct  = 24;
    int pop_gap_pct = 24;
    int cycle_count = 0;
    int n_bytes     = 0;
    int n_strings   = 0;

    url_percent_decoder_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    url_percent_decoder_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_item    (in_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: pop decided afresh every falling edge, so stalls land on
    // every phase of a multi-byte release from the back end.
    always @(negedge clk) begin
        pop = rst_n && ($urandom_range(99) >= pop_gap_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still expected",
                     cycle_count, pending);
            $display("url_percent_decoder_unit: mismatch");
            $finish;
        end
    end

    // Offer one byte until it is taken. Entered and left at a falling edge;
    // push is recomputed each cycle, including idle gaps while full.
    task automatic send_byte(input logic [7:0] b, input logic l);
        logic taken;
        taken = 1'b0;
        while (!taken) begin
            if ($urandom_range(99) < in_gap_pct) begin
                push = 1'b0;
            end else begin
                push = 1'b1;
                in_item.in_byte = b;
                in_item.in_last = l;
            end
            @(posedge clk);
            taken = push && !full;
            @(negedge clk);
        end
        push = 1'b0;
        n_bytes++;
        if (l) n_strings++;
    endtask

    task automatic send_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic drain_results();
        while (pending != 0) @(negedge clk);
    endtask

    // query_mode may only change with the decoder idle: every string has
    // been closed, so once the last result is out nothing is in flight.
    task automatic write_mode(input logic m);
        drain_results();
        repeat (SETTLE_TICKS) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [7:0] pick_hex();
        int v;
        v = $urandom_range(15);
        if (v < 10) return 8'(8'h30 + v);
        return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + v - 10);
    endfunction

    // Mostly well-formed escapes, pluses and text; the rest is raw noise
    // and broken escapes (lone '%', '%' with a single digit).
    task automatic send_random_string();
        logic [7:0] raw_q[$];
        int         len;
        int         kind;
        int         i;
        len = $urandom_range(1, 12);
        while (raw_q.size() < len) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                raw_q.push_back(upd_pkg::CH_PERCENT);
                raw_q.push_back(pick_hex());
                raw_q.push_back(pick_hex());
            end else if (kind < 55) begin
                raw_q.push_back(upd_pkg::CH_PLUS);
            end else if (kind < 75) begin
                raw_q.push_back(8'($urandom_range(32, 126)));
            end else if (kind < 90) begin
                raw_q.push_back(8'($urandom_range(255)));
            end else if (kind < 95) begin
                raw_q.push_back(upd_pkg::CH_PERCENT);
                raw_q.push_back(pick_hex());
                raw_q.push_back(8'($urandom_range(255)));
            end else begin
                raw_q.push_back(upd_pkg::CH_PERCENT);
            end
        end
        for (i = 0; i < raw_q.size(); i++)
            send_byte(raw_q[i], i == raw_q.size() - 1);
    endtask

    initial begin
        int ph;
        int phase_start;
        rst_n     = 1'b0;
        push      = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed, path mode: upper/lower hex, DEL and control values
        // folded to '_', a high value, '+' kept, a broken escape, '%' as
        // the final byte, '%' plus one digit at string end, zero and 0xFF.
        write_mode(1'b0);
        send_str("%4a%7F%0d%Ff+");
        send_str("%G%");
        send_str("%4");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Directed, query mode: '+' straight after '%', and an encoded '+'.
        write_mode(1'b1);
        send_str("%+");
        send_str("%2B");

        // Random phases, alternating the mode; phase two runs with no
        // idling on either side, phase three pauses for a full drain.
        for (ph = 0; ph < 6; ph++) begin
            write_mode(ph % 2 == 0);
            in_gap_pct  = (ph == 2) ? 0 : 24;
            pop_gap_pct = (ph == 2) ? 0 : 24;
            phase_start = n_bytes;
            while (n_bytes - phase_start < 56) begin
                send_random_string();
                if (ph == 3 && n_strings % 5 == 0) drain_results();
            end
        end
        in_gap_pct  = 24;
        pop_gap_pct = 24;

        drain_results();
        repeat (SETTLE_TICKS) @(negedge clk);

        $display("sent %0d bytes in %0d strings over path and query mode",
                 n_bytes, n_strings);
        $display("%0d decoded items checked, %0d failures", checked,
                 fail_count + pending);
        if (fail_count == 0 && pending == 0) begin
            $display("url_percent_decoder_unit: match");
        end else begin
            $display("url_percent_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule

[url_percent_decoder_unit.f]
src/upd_pkg.sv
src/upd_front.sv
src/upd_cmd_fifo.sv
src/upd_back.sv
src/url_percent_decoder_unit.sv
dv/url_percent_decoder_checker.sv
dv/tb_url_percent_decoder_unit.sv
